/* src/aes_isb_pkg.sv */
// ----------------------------------------------------------------------------
// aes_isb_pkg
// Types, constants and GF(2^8) helpers for the AES inverse S-box pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package aes_isb_pkg;

  typedef logic [7:0] byte_t;

  localparam byte_t AES_POLY_LOW     = 8'h1b;
  localparam byte_t INV_AFFINE_CONST = 8'h05;

  // multiply by x modulo x^8+x^4+x^3+x+1
  function automatic byte_t gf_mul_x(input byte_t a);
    gf_mul_x = {a[6:0], 1'b0} ^ (a[7] ? AES_POLY_LOW : 8'h00);
  endfunction

  function automatic byte_t gf_mul(input byte_t a, input byte_t b);
    byte_t acc;
    acc = '0;
    for (int k = 7; k >= 0; k--) begin
      acc = gf_mul_x(acc) ^ (a[k] ? b : 8'h00);
    end
    gf_mul = acc;
  endfunction

  // squaring is linear over GF(2)
  function automatic byte_t gf_sq(input byte_t a);
    gf_sq = gf_mul(a, a);
  endfunction

  // bit i = v[i+2] ^ v[i+5] ^ v[i+7], then ^ 0x05
  function automatic byte_t unmap_affine(input byte_t v);
    unmap_affine = {v[1:0], v[7:2]} ^ {v[4:0], v[7:5]} ^ {v[6:0], v[7]} ^ INV_AFFINE_CONST;
  endfunction

endpackage

`default_nettype wire

/* src/aes_inverse_sbox_top.sv */
// ----------------------------------------------------------------------------
// aes_inverse_sbox_top
// AES inverse S-box: inverse affine map, then GF(2^8) inverse as x^254.
// ----------------------------------------------------------------------------
// Channel   Dir  Signals                      Payload
// s_*       in   s_tvalid s_tready s_tdata    [7:0] in_byte
// m_*       out  m_tvalid m_tready m_tdata    [7:0] out_byte
//
// Four register stages, one request per cycle while the output is not stalled.
// Stage 1: affine map. Stage 2: a^2, a^3. Stage 3: a^14, a^15.
// Stage 4: a^240 * a^14 = a^254; stages 2-4 each feed squarings into a GF multiply.
// Each stage holds its item while the one after it is full and stalled;
// bubbles close up. Reset clears all valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module aes_inverse_sbox_top (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 s_tvalid,
  output logic                s_tready,
  input  aes_isb_pkg::byte_t  s_tdata,   // [7:0] in_byte
  output logic                m_tvalid,
  input  wire                 m_tready,
  output aes_isb_pkg::byte_t  m_tdata    // [7:0] out_byte
);
  import aes_isb_pkg::*;

  logic  v1, v2, v3, v4;
  logic  rdy1, rdy2, rdy3, rdy4;
  byte_t b1;
  byte_t a2, a3;
  byte_t a14, a15;
  byte_t res;
  byte_t a12;

  assign rdy4 = !v4 || m_tready;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;

  assign s_tready = rdy1;
  assign m_tvalid = v4;
  assign m_tdata  = res;

  assign a12 = gf_sq(gf_sq(a3));

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) v1 <= s_tvalid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      b1 <= unmap_affine(s_tdata);
    end
    if (rdy2) begin
      a2 <= gf_sq(b1);
      a3 <= gf_mul(gf_sq(b1), b1);
    end
    if (rdy3) begin
      a14 <= gf_mul(a12, a2);
      a15 <= gf_mul(a12, a3);
    end
    if (rdy4) begin
      res <= gf_mul(gf_sq(gf_sq(gf_sq(gf_sq(a15)))), a14);
    end
  end

endmodule

`default_nettype wire

/* src/aes_isb_checker.sv */
// ----------------------------------------------------------------------------
// aes_isb_checker
// Port-level checks for the AES inverse S-box pipeline, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module aes_isb_checker (
  input wire                 clk,
  input wire                 rst,
  input wire                 s_tvalid,
  input wire                 s_tready,
  input aes_isb_pkg::byte_t  s_tdata,
  input wire                 m_tvalid,
  input wire                 m_tready,
  input aes_isb_pkg::byte_t  m_tdata
);
  import aes_isb_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output request dropped or changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output stage");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) ##1 m_tready ##1 m_tready ##1 m_tready |=> m_tvalid)
    else $error("request not delivered after four flowing cycles");

  a_zero_case: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tdata == 8'h63) ##1 m_tready ##1 m_tready ##1 m_tready
      |=> m_tdata == 8'h00)
    else $error("0x63 did not map to 0x00");

endmodule

bind aes_inverse_sbox_top aes_isb_checker u_aes_isb_checker (.*);

`default_nettype wire

/* sim/aes_inverse_sbox_top_test.sv */
// ----------------------------------------------------------------------------
// aes_inverse_sbox_top_test
// Self-checking bench for the AES inverse S-box stream block. Each byte
// accepted on the input stream is run through a local GF(2^8) predictor. Its
// expected substitution is queued and compared in order with the output
// stream. Covers edge bytes, a full byte sweep, random bytes under mixed
// sender/receiver idling, and a long output stall that backs up the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module aes_inverse_sbox_top_test;

  timeunit 1ns;
  timeprecision 1ps;

  import aes_isb_pkg::*;

  localparam byte_t FIELD_POLY_LOW = 8'h1b;
  localparam byte_t UNMAP_CONST    = 8'h05;
  localparam int    STALL_LIMIT    = 5000;
  localparam int    DRAIN_CYCLES   = 12;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  s_tvalid = 1'b0;
  logic  s_tready;
  byte_t s_tdata = '0;
  logic  m_tvalid;
  logic  m_tready = 1'b0;
  byte_t m_tdata;

  byte_t expected_bytes[$];
  int    send_idle_pct = 0;
  int    recv_stall_pct = 0;
  int    hold_off_request = 0;
  int    hold_left = 0;
  int    mismatch_count = 0;
  int    req_count = 0;
  int    result_count = 0;
  int    quiet_cycles = 0;
  bit    req_taken = 1'b0;

  aes_inverse_sbox_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // product in GF(2^8), b scanned from its low bit up
  function automatic byte_t gf_times(input byte_t a, input byte_t b);
    byte_t prod;
    byte_t shifted;
    prod = '0;
    shifted = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) prod ^= shifted;
      shifted = {shifted[6:0], 1'b0} ^ (shifted[7] ? FIELD_POLY_LOW : 8'h00);
    end
    return prod;
  endfunction

  function automatic byte_t inv_sbox_of(input byte_t b);
    byte_t unmapped;
    byte_t pow;
    byte_t recip;
    for (int i = 0; i < 8; i++) begin
      unmapped[i] = b[(i + 2) % 8] ^ b[(i + 5) % 8] ^ b[(i + 7) % 8];
    end
    unmapped ^= UNMAP_CONST;
    // x^254 = x^2 * x^4 * ... * x^128, zero stays zero
    pow = unmapped;
    recip = 8'h01;
    for (int k = 0; k < 7; k++) begin
      pow = gf_times(pow, pow);
      recip = gf_times(recip, pow);
    end
    return recip;
  endfunction

  // request capture and result check
  always @(posedge clk) begin
    byte_t want;
    req_taken = s_tvalid && s_tready && !rst;
    if (req_taken) begin
      expected_bytes.push_back(inv_sbox_of(s_tdata));
      req_count++;
    end
    if (!rst && m_tvalid && m_tready) begin
      result_count++;
      if (expected_bytes.size() == 0) begin
        $error("unexpected result: out_byte actual 0x%02h", m_tdata);
        mismatch_count++;
      end else begin
        want = expected_bytes.pop_front();
        if (m_tdata !== want) begin
          $error("out_byte mismatch: expected 0x%02h actual 0x%02h", want, m_tdata);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (!s_tvalid && expected_bytes.size() == 0)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("timeout: no request or result for %0d cycles", STALL_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // receiver: random stalls plus an optional long hold-off
  always @(negedge clk) begin
    if (hold_off_request != 0) begin
      hold_left = hold_off_request;
      hold_off_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // called and returns at a falling edge
  task automatic send_byte(input byte_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    do @(negedge clk); while (!req_taken);
  endtask

  task automatic test_edge_bytes();
    byte_t edges[$];
    edges = '{8'h00, 8'hff, 8'h63, 8'h52, 8'h7f, 8'h80, 8'hfe, 8'h01,
              8'haa, 8'h55, 8'h7d, 8'h0c};
    for (int i = 0; i < 8; i++) begin
      edges.push_back(byte_t'(1 << i));
    end
    foreach (edges[i]) send_byte(edges[i]);
  endtask

  task automatic test_full_sweep();
    for (int v = 0; v < 256; v++) begin
      send_byte(byte_t'(v));
    end
  endtask

  task automatic test_random_bytes(input int count, input int idle_pct, input int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_byte(byte_t'($urandom_range(255)));
  endtask

  task automatic test_long_stall();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_request = 300;
    repeat (60) send_byte(byte_t'($urandom_range(255)));
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_edge_bytes();
    test_full_sweep();
    test_random_bytes(270, 0, 0);
    test_random_bytes(270, 75, 0);
    test_random_bytes(270, 0, 75);
    test_long_stall();
    test_random_bytes(270, 21, 21);

    s_tvalid <= 1'b0;
    while (expected_bytes.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Checked %0d results for %0d requests: edge bytes, all 256 values,",
             result_count, req_count);
    $display("random bytes under four idle/stall mixes and a 300-cycle output hold.");
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* sim.f */
src/aes_isb_pkg.sv
src/aes_inverse_sbox_top.sv
src/aes_isb_checker.sv
sim/aes_inverse_sbox_top_test.sv
